[sv/utf8d_pkg.sv]
`timescale 1ns / 1ps
package utf8d_pkg;

    localparam logic [2:0] MAX_COUNT = 3'd4;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SHORT      = 4'd1,
        ST_LEAD_TRAIL = 4'd2,
        ST_OVERLONG2  = 4'd3,
        ST_BAD_TRAIL  = 4'd4,
        ST_OVERLONG3  = 4'd5,
        ST_OVERLONG4  = 4'd6,
        ST_TOO_HIGH   = 4'd7,
        ST_SURROGATE  = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [2:0] valid_count;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [20:0] code_point;
        logic [2:0]  seq_length;
    } t_out;

    typedef struct packed {
        t_status    status;
        logic [2:0] need;
        logic [2:0] avail;
        logic [7:0] lead;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_lead;

    typedef struct packed {
        t_status     status;
        logic [2:0]  need;
        logic [20:0] cp;
    } t_pack;

endpackage

[sv/utf8_sequence_decoder_top.sv]
`timescale 1ns / 1ps
// UTF-8 sequence decoder. Each input beat carries a window of four bytes and
// the count of bytes present in it; each output beat carries the status, the
// code point and the length of the first sequence in that window.
// Both channels use valid and ready, and a beat moves when both are high.
// The block has three register stages: lead byte classification, trailing
// byte checks with code point packing, and the range checks that fill the
// output register. One beat is taken in every cycle while the receiver
// keeps up. Each stage holds its beat while the stage after it is full and
// stalled. The ready chain is combinational, so once every stage is full a
// stall at the output drops the input ready in the same cycle and no beat
// is lost or repeated; empty stages still fill while the output is stalled.
// The synchronous active-low reset empties all stages. No state is kept
// between beats.
module utf8_sequence_decoder_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  utf8d_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output utf8d_pkg::t_out o_data
);
    import utf8d_pkg::*;

    logic  w_s1_valid;
    t_lead w_s1_data;
    logic  w_s2_ready;
    logic  w_s2_valid;
    t_pack w_s2_data;
    logic  w_s3_ready;

    utf8d_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_s1_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s1_data)
    );

    utf8d_trail u_trail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .i_ready (w_s3_ready),
        .o_data  (w_s2_data)
    );

    utf8d_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s3_ready),
        .i_data  (w_s2_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.code_point == '0 &&
        o_data.seq_length == '0)
        else $error("error beat carries a nonzero code point or length");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_OK |-> o_data.code_point <= CP_MAX &&
        (o_data.code_point < SURR_LO || o_data.code_point > SURR_HI) &&
        o_data.seq_length != 3'd0 && o_data.seq_length <= MAX_COUNT)
        else $error("good beat carries an invalid code point or length");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_valid && !w_s2_ready |=> w_s1_valid && $stable(w_s1_data))
        else $error("first stage dropped or changed a stalled beat");

endmodule

[sv/utf8d_classify.sv]
`timescale 1ns / 1ps
module utf8d_classify (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  utf8d_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output utf8d_pkg::t_lead o_data
);
    import utf8d_pkg::*;

    logic  r_valid;
    t_lead r_data;
    t_lead n_data;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_data   = r_data;

    always_comb begin
        n_data.lead  = i_data.byte0;
        n_data.byte1 = i_data.byte1;
        n_data.byte2 = i_data.byte2;
        n_data.byte3 = i_data.byte3;
        n_data.avail = (i_data.valid_count > MAX_COUNT) ? MAX_COUNT : i_data.valid_count;
        n_data.status = ST_OK;
        n_data.need   = 3'd1;
        if (n_data.avail == 3'd0) begin
            n_data.status = ST_SHORT;
        end else if (i_data.byte0 inside {[8'h00:8'h7F]}) begin
            n_data.need = 3'd1;
        end else if (i_data.byte0 inside {[8'h80:8'hBF]}) begin
            n_data.status = ST_LEAD_TRAIL;
        end else if (i_data.byte0 inside {8'hC0, 8'hC1}) begin
            n_data.status = ST_OVERLONG2;
        end else if (i_data.byte0 inside {[8'hC2:8'hDF]}) begin
            n_data.need = 3'd2;
        end else if (i_data.byte0 inside {8'hE0, 8'hF0}) begin
            n_data.need = (i_data.byte0 == 8'hE0) ? 3'd3 : 3'd4;
            if (n_data.avail < 3'd2) begin
                n_data.status = ST_SHORT;
            end else if (i_data.byte1 < 8'h80) begin
                n_data.status = ST_BAD_TRAIL;
            end else if (i_data.byte0 == 8'hE0 && i_data.byte1 < 8'hA0) begin
                n_data.status = ST_OVERLONG3;
            end else if (i_data.byte0 == 8'hF0 && i_data.byte1 < 8'h90) begin
                n_data.status = ST_OVERLONG4;
            end
        end else if (i_data.byte0 inside {[8'hE1:8'hEF]}) begin
            n_data.need = 3'd3;
        end else if (i_data.byte0 inside {[8'hF1:8'hF7]}) begin
            n_data.need = 3'd4;
        end else begin
            n_data.status = ST_TOO_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

[sv/utf8d_trail.sv]
`timescale 1ns / 1ps
module utf8d_trail (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  utf8d_pkg::t_lead i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output utf8d_pkg::t_pack o_data
);
    import utf8d_pkg::*;

    logic       r_valid;
    t_pack      r_data;
    t_pack      n_data;
    logic [7:0] w_trail [1:3];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_trail[1] = i_data.byte1;
    assign w_trail[2] = i_data.byte2;
    assign w_trail[3] = i_data.byte3;

    always_comb begin
        n_data.status = i_data.status;
        n_data.need   = i_data.need;
        if (i_data.status == ST_OK) begin
            for (int i = 3; i >= 1; i--) begin
                if (3'(i) < i_data.need) begin
                    if (3'(i) >= i_data.avail) begin
                        n_data.status = ST_SHORT;
                    end else if (w_trail[i] < 8'h80 || w_trail[i] > 8'hBF) begin
                        n_data.status = ST_BAD_TRAIL;
                    end
                end
            end
        end
        case (i_data.need)
            3'd1:    n_data.cp = {13'd0, i_data.lead};
            3'd2:    n_data.cp = {10'd0, i_data.lead[4:0], i_data.byte1[5:0]};
            3'd3:    n_data.cp = {5'd0, i_data.lead[3:0], i_data.byte1[5:0],
                                  i_data.byte2[5:0]};
            default: n_data.cp = {i_data.lead[2:0], i_data.byte1[5:0],
                                  i_data.byte2[5:0], i_data.byte3[5:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

[sv/utf8d_range.sv]
`timescale 1ns / 1ps
module utf8d_range (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  utf8d_pkg::t_pack i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output utf8d_pkg::t_out  o_data
);
    import utf8d_pkg::*;

    logic    r_valid;
    t_out    r_data;
    t_status w_status;
    t_out    n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        w_status = i_data.status;
        if (i_data.status == ST_OK) begin
            if (i_data.cp >= SURR_LO && i_data.cp <= SURR_HI) begin
                w_status = ST_SURROGATE;
            end else if (i_data.cp > CP_MAX) begin
                w_status = ST_TOO_HIGH;
            end
        end
        n_data.status = w_status;
        if (w_status == ST_OK) begin
            n_data.code_point = i_data.cp;
            n_data.seq_length = i_data.need;
        end else begin
            n_data.code_point = '0;
            n_data.seq_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule
